// ===== hdl/pds_pkg.sv =====
// shared constants, codes and control structs for the particle depth sorter
package pds_pkg;

    localparam int MAX_PARTICLES = 1024;
    localparam int ADDR_W        = $clog2(MAX_PARTICLES);
    localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
    localparam int POS_W         = 24;
    localparam int DIR_W         = 16;
    localparam int PROD_W        = POS_W + DIR_W;
    localparam int DEPTH_W       = 41;
    localparam int TAG_W         = 16;
    localparam int SLOT_W        = 10;
    localparam int WIN_W         = 11;
    localparam int FC_W          = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int WORD_W        = TAG_W + DEPTH_W;

    localparam logic [WIN_W-1:0] WINDOW_LEN_RST = 11'd200;
    localparam logic [FC_W-1:0]  FULL_AFTER_RST = 8'd20;
    localparam logic [FC_W-1:0]  FC_MAX         = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAM_X      = 3'd0,
        CFG_CAM_Y      = 3'd1,
        CFG_CAM_Z      = 3'd2,
        CFG_WINDOW_LEN = 3'd3,
        CFG_FULL_AFTER = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_READ = 1'b1
    } t_kind;

    typedef struct packed {
        logic accept;
        logic load_wr;
        logic rd_slot;
        logic out_read;
        logic setup;
        logic p_start;
        logic p_fetch;
        logic p_cmp;
        logic p_end;
        logic out_status;
    } t_cmd;

    typedef struct packed {
        logic do_pass;
        logic at_end;
        logic full;
        logic swapped;
        logic out_free;
    } t_stat;

endpackage

// ===== hdl/pds_datapath.sv =====
// datapath: config registers, depth multipliers, particle store, bubble pass and result register
module pds_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pds_pkg::t_cmd                         i_cmd,
    output pds_pkg::t_stat                        o_stat,
    input  logic                                  i_cfg_valid,
    input  logic [pds_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pds_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic signed [pds_pkg::POS_W-1:0]      i_pos_x,
    input  logic signed [pds_pkg::POS_W-1:0]      i_pos_y,
    input  logic signed [pds_pkg::POS_W-1:0]      i_pos_z,
    input  logic [pds_pkg::TAG_W-1:0]             i_tag,
    input  logic [pds_pkg::SLOT_W-1:0]            i_slot,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output logic                                  o_result_kind,
    output logic [pds_pkg::TAG_W-1:0]             o_tag_out,
    output logic signed [pds_pkg::DEPTH_W-1:0]    o_depth_out,
    output logic                                  o_slot_valid,
    output logic                                  o_full_sorted,
    output logic [pds_pkg::CNT_W-1:0]             o_frame_count,
    output logic                                  o_overflow
);

    logic signed [pds_pkg::DIR_W-1:0]   r_cam_x, r_cam_y, r_cam_z;
    logic [pds_pkg::WIN_W-1:0]          r_wl;
    logic [pds_pkg::FC_W-1:0]           r_fsa, r_fc;
    logic [pds_pkg::CNT_W-1:0]          r_lp, r_sorted, r_n;
    logic                               r_ovf, r_st_ovf, r_full, r_swapped;
    logic signed [pds_pkg::PROD_W-1:0]  r_px, r_py, r_pz;
    logic [pds_pkg::TAG_W-1:0]          r_tag;
    logic [pds_pkg::SLOT_W-1:0]         r_slot;
    logic [pds_pkg::ADDR_W-1:0]         r_start, r_i, r_last_idx;
    logic [pds_pkg::WORD_W-1:0]         r_cur, r_rdata;
    logic [pds_pkg::WORD_W-1:0]         r_mem [0:pds_pkg::MAX_PARTICLES-1];

    logic signed [pds_pkg::PROD_W-1:0]  w_px, w_py, w_pz;
    logic signed [pds_pkg::PROD_W+1:0]  w_sum;
    logic                               w_room, w_big, w_full, w_tail, w_swap;
    logic [pds_pkg::CNT_W:0]            w_n12, w_wl1, w_start12;
    logic                               w_re, w_we;
    logic [pds_pkg::ADDR_W-1:0]         w_raddr, w_waddr;
    logic [pds_pkg::WORD_W-1:0]         w_wdata;
    logic                               w_slot_ok;

    assign w_px = i_pos_x * r_cam_x;
    assign w_py = i_pos_y * r_cam_y;
    assign w_pz = i_pos_z * r_cam_z;
    assign w_sum = (pds_pkg::PROD_W+2)'(r_px) + (pds_pkg::PROD_W+2)'(r_py)
                 + (pds_pkg::PROD_W+2)'(r_pz);

    assign w_room    = r_lp < pds_pkg::CNT_W'(pds_pkg::MAX_PARTICLES);
    assign w_big     = r_lp > pds_pkg::CNT_W'(1);
    assign w_full    = w_big && (r_fc > r_fsa);
    assign w_n12     = {1'b0, r_lp};
    assign w_wl1     = {1'b0, r_wl} + (pds_pkg::CNT_W+1)'(1);
    assign w_tail    = w_n12 > w_wl1;
    assign w_start12 = w_tail ? (w_n12 - {1'b0, r_wl}) : '0;
    assign w_swap    = $signed(r_cur[pds_pkg::DEPTH_W-1:0])
                     > $signed(r_rdata[pds_pkg::DEPTH_W-1:0]);
    assign w_slot_ok = {1'b0, r_slot} < r_sorted;

    assign o_stat.do_pass  = w_big && (w_full || ((w_start12 + (pds_pkg::CNT_W+1)'(1)) < w_n12));
    assign o_stat.at_end   = (r_i + pds_pkg::ADDR_W'(1)) == r_last_idx;
    assign o_stat.full     = r_full;
    assign o_stat.swapped  = r_swapped;
    assign o_stat.out_free = !o_out_valid || !i_out_stall;

    always_comb begin
        w_re    = 1'b0;
        w_raddr = r_slot[pds_pkg::ADDR_W-1:0];
        if (i_cmd.rd_slot) begin
            w_re = 1'b1;
        end else if (i_cmd.p_start) begin
            w_re    = 1'b1;
            w_raddr = r_start;
        end else if (i_cmd.p_fetch) begin
            w_re    = 1'b1;
            w_raddr = r_i + pds_pkg::ADDR_W'(1);
        end else if (i_cmd.p_cmp && !o_stat.at_end) begin
            w_re    = 1'b1;
            w_raddr = r_i + pds_pkg::ADDR_W'(2);
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_lp[pds_pkg::ADDR_W-1:0];
        w_wdata = {r_tag, w_sum[pds_pkg::DEPTH_W-1:0]};
        if (i_cmd.load_wr) begin
            w_we = w_room;
        end else if (i_cmd.p_cmp) begin
            w_we    = 1'b1;
            w_waddr = r_i;
            w_wdata = w_swap ? r_rdata : r_cur;
        end else if (i_cmd.p_end) begin
            w_we    = 1'b1;
            w_waddr = r_last_idx;
            w_wdata = r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_px   <= w_px;
            r_py   <= w_py;
            r_pz   <= w_pz;
            r_tag  <= i_tag;
            r_slot <= i_slot;
        end
        if (i_cmd.setup) begin
            r_n        <= r_lp;
            r_last_idx <= r_lp[pds_pkg::ADDR_W-1:0] - pds_pkg::ADDR_W'(1);
            r_start    <= w_full ? '0 : w_start12[pds_pkg::ADDR_W-1:0];
        end
        if (i_cmd.p_start) begin
            r_i <= r_start;
        end else if (i_cmd.p_cmp) begin
            r_i <= r_i + pds_pkg::ADDR_W'(1);
        end
        if (i_cmd.p_fetch) begin
            r_cur <= r_rdata;
        end else if (i_cmd.p_cmp && !w_swap) begin
            r_cur <= r_rdata;
        end
        if (i_cmd.out_read) begin
            o_result_kind <= pds_pkg::KIND_READ;
            o_tag_out     <= w_slot_ok ? r_rdata[pds_pkg::WORD_W-1:pds_pkg::DEPTH_W] : '0;
            o_depth_out   <= w_slot_ok ? r_rdata[pds_pkg::DEPTH_W-1:0] : '0;
            o_slot_valid  <= w_slot_ok;
            o_full_sorted <= 1'b0;
            o_frame_count <= '0;
            o_overflow    <= 1'b0;
        end else if (i_cmd.out_status) begin
            o_result_kind <= pds_pkg::KIND_LOAD;
            o_tag_out     <= '0;
            o_depth_out   <= '0;
            o_slot_valid  <= 1'b0;
            o_full_sorted <= r_full;
            o_frame_count <= r_n;
            o_overflow    <= r_st_ovf;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x     <= '0;
            r_cam_y     <= '0;
            r_cam_z     <= '0;
            r_wl        <= pds_pkg::WINDOW_LEN_RST;
            r_fsa       <= pds_pkg::FULL_AFTER_RST;
            r_fc        <= '0;
            r_lp        <= '0;
            r_sorted    <= '0;
            r_ovf       <= 1'b0;
            r_st_ovf    <= 1'b0;
            r_full      <= 1'b0;
            r_swapped   <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    pds_pkg::CFG_CAM_X:      r_cam_x <= i_cfg_data;
                    pds_pkg::CFG_CAM_Y:      r_cam_y <= i_cfg_data;
                    pds_pkg::CFG_CAM_Z:      r_cam_z <= i_cfg_data;
                    pds_pkg::CFG_WINDOW_LEN: r_wl    <= i_cfg_data[pds_pkg::WIN_W-1:0];
                    pds_pkg::CFG_FULL_AFTER: r_fsa   <= i_cfg_data[pds_pkg::FC_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load_wr) begin
                if (w_room) begin
                    r_lp <= r_lp + pds_pkg::CNT_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.setup) begin
                r_sorted <= r_lp;
                r_lp     <= '0;
                r_st_ovf <= r_ovf;
                r_ovf    <= 1'b0;
                r_full   <= w_full;
                if (w_full) begin
                    r_fc <= pds_pkg::FC_W'(1);
                end else if (r_fc < pds_pkg::FC_MAX) begin
                    r_fc <= r_fc + pds_pkg::FC_W'(1);
                end
            end
            if (i_cmd.p_start) begin
                r_swapped <= 1'b0;
            end else if (i_cmd.p_cmp && w_swap) begin
                r_swapped <= 1'b1;
            end
            if (i_cmd.out_read || i_cmd.out_status) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_cmp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.p_cmp |-> r_i < r_last_idx)
        else $error("compare step beyond pass end");
    a_lp_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_wr && w_room) |=> r_lp == $past(r_lp) + pds_pkg::CNT_W'(1))
        else $error("load pointer did not advance");
    a_setup_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.setup |=> (r_lp == '0) && !r_ovf)
        else $error("frame end did not clear load state");
`endif

endmodule

// ===== hdl/pds_ctrl.sv =====
// controller state machine sequencing loads, reads and sort passes
module pds_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_kind,
    input  logic           i_last,
    output logic           o_in_stall,
    input  pds_pkg::t_stat i_stat,
    output pds_pkg::t_cmd  o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_LOAD_WR = 10'b0000000010,
        S_RD_ISS  = 10'b0000000100,
        S_RD_OUT  = 10'b0000001000,
        S_SETUP   = 10'b0000010000,
        S_P_START = 10'b0000100000,
        S_P_FETCH = 10'b0001000000,
        S_P_CMP   = 10'b0010000000,
        S_P_END   = 10'b0100000000,
        S_STATUS  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_last, w_acc;

    assign o_in_stall = r_state != S_IDLE;
    assign w_acc      = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = (i_kind == pds_pkg::KIND_READ) ? S_RD_ISS : S_LOAD_WR;
                end
            end
            S_LOAD_WR: begin
                o_cmd.load_wr = 1'b1;
                n_state = r_last ? S_SETUP : S_IDLE;
            end
            S_RD_ISS: begin
                o_cmd.rd_slot = 1'b1;
                n_state = S_RD_OUT;
            end
            S_RD_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_read = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state = i_stat.do_pass ? S_P_START : S_STATUS;
            end
            S_P_START: begin
                o_cmd.p_start = 1'b1;
                n_state = S_P_FETCH;
            end
            S_P_FETCH: begin
                o_cmd.p_fetch = 1'b1;
                n_state = S_P_CMP;
            end
            S_P_CMP: begin
                o_cmd.p_cmp = 1'b1;
                if (i_stat.at_end) begin
                    n_state = S_P_END;
                end
            end
            S_P_END: begin
                o_cmd.p_end = 1'b1;
                n_state = (i_stat.full && i_stat.swapped) ? S_P_START : S_STATUS;
            end
            S_STATUS: begin
                if (i_stat.out_free) begin
                    o_cmd.out_status = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_acc) begin
                r_last <= i_last;
            end
        end
    end

`ifndef SYNTHESIS
    a_load_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_kind == pds_pkg::KIND_LOAD) |=> r_state == S_LOAD_WR)
        else $error("load transaction not written");
    a_read_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_kind == pds_pkg::KIND_READ) |=> r_state == S_RD_ISS)
        else $error("read transaction not issued");
    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_status |=> r_state == S_IDLE)
        else $error("status result did not end the frame");
`endif

endmodule

// ===== hdl/particle_depth_sorter_top.sv =====
// top level of the particle depth sorter
//  channel | direction | handshake           | payload
//  in      | input     | i_in_valid/o_in_stall  | kind, pos_x/y/z, tag, last, slot
//  out     | output    | o_out_valid/i_out_stall| result_kind, tag_out, depth_out, status
//  cfg     | input     | i_cfg_valid/o_cfg_ready| cfg_index, cfg_data
// a load passes through S_LOAD_WR; a read through S_RD_ISS and S_RD_OUT, plus any output stall
// frame end: a tail pass over the last particles, or a full sort
//   (repeated bubble passes, one compare per cycle, store with one read and one write port)
// input stalls whenever the controller is not idle; reset is synchronous, active low
module particle_depth_sorter_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_kind,
    input  logic signed [pds_pkg::POS_W-1:0]      i_pos_x,
    input  logic signed [pds_pkg::POS_W-1:0]      i_pos_y,
    input  logic signed [pds_pkg::POS_W-1:0]      i_pos_z,
    input  logic [pds_pkg::TAG_W-1:0]             i_tag,
    input  logic                                  i_last,
    input  logic [pds_pkg::SLOT_W-1:0]            i_slot,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_result_kind,
    output logic [pds_pkg::TAG_W-1:0]             o_tag_out,
    output logic signed [pds_pkg::DEPTH_W-1:0]    o_depth_out,
    output logic                                  o_slot_valid,
    output logic                                  o_full_sorted,
    output logic [pds_pkg::CNT_W-1:0]             o_frame_count,
    output logic                                  o_overflow,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [pds_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pds_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    pds_pkg::t_cmd  w_cmd;
    pds_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    pds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_last     (i_last),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pds_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_tag         (i_tag),
        .i_slot        (i_slot),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_result_kind (o_result_kind),
        .o_tag_out     (o_tag_out),
        .o_depth_out   (o_depth_out),
        .o_slot_valid  (o_slot_valid),
        .o_full_sorted (o_full_sorted),
        .o_frame_count (o_frame_count),
        .o_overflow    (o_overflow)
    );

endmodule

// ===== dv/particle_depth_sorter_checker.sv =====
// scoreboard for the particle depth sorter: predicts every result and compares it field by field
`timescale 1ns / 1ps
module particle_depth_sorter_checker
    import pds_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic                       i_kind,
    input  logic signed [POS_W-1:0]    i_pos_x,
    input  logic signed [POS_W-1:0]    i_pos_y,
    input  logic signed [POS_W-1:0]    i_pos_z,
    input  logic [TAG_W-1:0]           i_tag,
    input  logic                       i_last,
    input  logic [SLOT_W-1:0]          i_slot,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic                       i_result_kind,
    input  logic [TAG_W-1:0]           i_tag_out,
    input  logic [DEPTH_W-1:0]         i_depth_out,
    input  logic                       i_slot_valid,
    input  logic                       i_full_sorted,
    input  logic [CNT_W-1:0]           i_frame_count,
    input  logic                       i_overflow,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);

    typedef struct {
        logic               rkind;
        logic [TAG_W-1:0]   tag;
        logic [DEPTH_W-1:0] depth;
        logic               svalid;
        logic               fsorted;
        logic [CNT_W-1:0]   count;
        logic               ovf;
    } t_sorter_result;

    t_sorter_result         want_q[$];
    logic signed [41:0]     depth_mem [MAX_PARTICLES];
    logic [TAG_W-1:0]       tag_mem [MAX_PARTICLES];
    int                     load_ptr;
    int                     shown_cnt;
    int                     frame_ctr;
    logic                   ovf_seen;
    logic signed [DIR_W-1:0] cam_x, cam_y, cam_z;
    int                     win_len;
    int                     full_after;

    assign o_pending = want_q.size();

    function automatic void swap_entries(int a, int b);
        logic signed [41:0] d;
        logic [TAG_W-1:0]   t;
        d = depth_mem[a];
        t = tag_mem[a];
        depth_mem[a] = depth_mem[b];
        tag_mem[a] = tag_mem[b];
        depth_mem[b] = d;
        tag_mem[b] = t;
    endfunction

    function automatic void sort_frame(int n);
        int start;
        logic full;
        t_sorter_result r;
        full = 1'b0;
        if (n > 1) begin
            if (frame_ctr > full_after) begin
                for (int i = 1; i < n; i++)
                    for (int j = i; j > 0 && depth_mem[j-1] > depth_mem[j]; j--)
                        swap_entries(j - 1, j);
                frame_ctr = 0;
                full = 1'b1;
            end else begin
                start = (n > win_len + 1) ? n - win_len : 0;
                for (int i = start; i + 1 < n; i++)
                    if (depth_mem[i] > depth_mem[i+1])
                        swap_entries(i, i + 1);
            end
        end
        if (frame_ctr < 255)
            frame_ctr++;
        r = '{KIND_LOAD, '0, '0, 1'b0, full, n[CNT_W-1:0], ovf_seen};
        want_q = {want_q, r};
        shown_cnt = n;
        load_ptr = 0;
        ovf_seen = 1'b0;
    endfunction

    function automatic void predict_item();
        t_sorter_result r;
        if (i_kind == KIND_READ) begin
            r = '{KIND_READ, '0, '0, 1'b0, 1'b0, '0, 1'b0};
            if (int'(i_slot) < shown_cnt) begin
                r.tag = tag_mem[i_slot];
                r.depth = depth_mem[i_slot][DEPTH_W-1:0];
                r.svalid = 1'b1;
            end
            want_q = {want_q, r};
            return;
        end
        if (load_ptr < MAX_PARTICLES) begin
            depth_mem[load_ptr] = i_pos_x * cam_x + i_pos_y * cam_y + i_pos_z * cam_z;
            tag_mem[load_ptr] = i_tag;
            load_ptr++;
        end else begin
            ovf_seen = 1'b1;
        end
        if (i_last)
            sort_frame(load_ptr);
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_sorter_result w;
        if (!i_rst_n) begin
            want_q.delete();
            o_fail_count = 0;
            load_ptr = 0;
            shown_cnt = 0;
            frame_ctr = 0;
            ovf_seen = 1'b0;
            cam_x = '0;
            cam_y = '0;
            cam_z = '0;
            win_len = WINDOW_LEN_RST;
            full_after = FULL_AFTER_RST;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CAM_X:      cam_x = i_cfg_data;
                    CFG_CAM_Y:      cam_y = i_cfg_data;
                    CFG_CAM_Z:      cam_z = i_cfg_data;
                    CFG_WINDOW_LEN: win_len = i_cfg_data[WIN_W-1:0];
                    CFG_FULL_AFTER: full_after = i_cfg_data[FC_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (want_q.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    o_fail_count++;
                end else begin
                    w = want_q.pop_front();
                    check_field("result_kind", w.rkind, i_result_kind);
                    check_field("tag_out", w.tag, i_tag_out);
                    check_field("depth_out", w.depth, i_depth_out);
                    check_field("slot_valid", w.svalid, i_slot_valid);
                    check_field("full_sorted", w.fsorted, i_full_sorted);
                    check_field("frame_count", w.count, i_frame_count);
                    check_field("overflow", w.ovf, i_overflow);
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_item();
        end
    end

endmodule

// ===== dv/particle_depth_sorter_top_tb.sv =====
// testbench top for the particle depth sorter: stimulus, flow control and verdict
`timescale 1ns / 1ps
module particle_depth_sorter_top_tb;
    import pds_pkg::*;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_kind;
    logic signed [POS_W-1:0] i_pos_x, i_pos_y, i_pos_z;
    logic [TAG_W-1:0]        i_tag;
    logic                    i_last;
    logic [SLOT_W-1:0]       i_slot;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic                    o_result_kind;
    logic [TAG_W-1:0]        o_tag_out;
    logic signed [DEPTH_W-1:0] o_depth_out;
    logic                    o_slot_valid;
    logic                    o_full_sorted;
    logic [CNT_W-1:0]        o_frame_count;
    logic                    o_overflow;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    int                      fail_count;
    int                      pending;

    int  burst_left;
    int  items_sent;
    int  last_frame_n;
    int  hold_left = 0;
    logic hold_used = 1'b0;
    logic hold_req = 1'b0;
    logic no_idle;

    particle_depth_sorter_top dut (.*);

    particle_depth_sorter_checker checker_inst (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_kind,
        .i_pos_x, .i_pos_y, .i_pos_z, .i_tag, .i_last, .i_slot,
        .i_out_valid(o_out_valid), .i_out_stall, .i_result_kind(o_result_kind),
        .i_tag_out(o_tag_out), .i_depth_out(o_depth_out), .i_slot_valid(o_slot_valid),
        .i_full_sorted(o_full_sorted), .i_frame_count(o_frame_count),
        .i_overflow(o_overflow), .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_index, .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // receiver stall pattern, with one long hold-off on request
    always @(posedge i_clk) begin
        int mode;
        mode = int'(($time / 256) % 3);
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_used) begin
            i_out_stall <= 1'b1;
            hold_left <= 399;
            hold_used <= 1'b1;
        end else if (mode == 0) begin
            i_out_stall <= 1'b0;
        end else if (mode == 1) begin
            i_out_stall <= ($urandom_range(0, 3) == 0);
        end else begin
            i_out_stall <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic drive_item(logic kind, logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                              logic signed [POS_W-1:0] z, logic [TAG_W-1:0] tag, logic last,
                              logic [SLOT_W-1:0] slot);
        int gap;
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_pos_x <= x;
        i_pos_y <= y;
        i_pos_z <= z;
        i_tag <= tag;
        i_last <= last;
        i_slot <= slot;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else if (!no_idle) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
    endtask

    task automatic load_part(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                             logic signed [POS_W-1:0] z, logic [TAG_W-1:0] tag, logic last);
        drive_item(KIND_LOAD, x, y, z, tag, last, SLOT_W'($urandom));
    endtask

    task automatic read_slot(logic [SLOT_W-1:0] slot);
        drive_item(KIND_READ, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                   TAG_W'($urandom), 1'($urandom_range(0, 1)), slot);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [POS_W-1:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return 24'sh7fffff;
            1: return -24'sh800000;
            2: return POS_W'($urandom_range(0, 4)) - 24'sd2;
            default: return POS_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_dir();
        case ($urandom_range(0, 4))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(0, 6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_frame();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(2, 30);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 5) == 0)
                read_slot(($urandom_range(0, 3) == 0) ? SLOT_W'($urandom)
                          : SLOT_W'($urandom_range(0, last_frame_n + 1)));
            load_part(rand_pos(), rand_pos(), rand_pos(), TAG_W'($urandom), k == n - 1);
        end
        if (n > 0)
            last_frame_n = n;
        repeat ($urandom_range(0, 4))
            read_slot(($urandom_range(0, 4) == 0) ? SLOT_W'($urandom)
                      : SLOT_W'($urandom_range(0, last_frame_n)));
    endtask

    initial begin
        int n_frames;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_kind <= KIND_LOAD;
        i_pos_x <= '0;
        i_pos_y <= '0;
        i_pos_z <= '0;
        i_tag <= '0;
        i_last <= 1'b0;
        i_slot <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_CAM_X;
        i_cfg_data <= '0;
        burst_left = 0;
        items_sent = 0;
        last_frame_n = 0;
        no_idle = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: out of range read before any frame, extremes, ties, small frames
        read_slot(10'd0);
        write_reg(CFG_CAM_X, 16'h7fff);
        write_reg(CFG_CAM_Y, 16'h8000);
        write_reg(CFG_CAM_Z, 16'h0001);
        write_reg(CFG_WINDOW_LEN, 16'd1);
        write_reg(CFG_FULL_AFTER, 16'd0);
        load_part(24'sh7fffff, -24'sh800000, 24'sh7fffff, 16'hffff, 1'b1);
        read_slot(10'd0);
        read_slot(10'd1);
        load_part(-24'sh800000, 24'sh7fffff, -24'sh800000, 16'h0000, 1'b0);
        load_part(24'sd5, 24'sd5, 24'sd5, 16'h0001, 1'b0);
        load_part(24'sd5, 24'sd5, 24'sd5, 16'h0002, 1'b0);
        read_slot(10'd1);
        load_part(24'sh7fffff, -24'sh800000, 24'sh7fffff, 16'h0003, 1'b1);
        for (int s = 0; s < 4; s++)
            read_slot(SLOT_W'(s));
        read_slot(10'd1023);
        last_frame_n = 4;

        // frame counter saturation with single particle frames
        write_reg(CFG_FULL_AFTER, 16'd255);
        write_reg(CFG_WINDOW_LEN, 16'd1024);
        no_idle = 1'b1;
        for (int f = 0; f < 260; f++)
            load_part(rand_pos(), rand_pos(), rand_pos(), TAG_W'($urandom), 1'b1);
        no_idle = 1'b0;
        read_slot(10'd1023);
        read_slot(10'd0);
        write_reg(CFG_FULL_AFTER, 16'd254);
        for (int k = 0; k < 5; k++)
            load_part(rand_pos(), rand_pos(), rand_pos(), TAG_W'($urandom), k == 4);
        last_frame_n = 5;
        read_slot(10'd4);

        // long receiver hold-off while reads keep coming
        hold_req = 1'b1;
        for (int k = 0; k < 40; k++)
            read_slot(SLOT_W'($urandom_range(0, 6)));

        // random phases, each with its own setting
        while (items_sent < 650) begin
            write_reg(CFG_CAM_X, rand_dir());
            write_reg(CFG_CAM_Y, rand_dir());
            write_reg(CFG_CAM_Z, rand_dir());
            case ($urandom_range(0, 3))
                0: write_reg(CFG_WINDOW_LEN, 16'd1);
                1: write_reg(CFG_WINDOW_LEN, 16'd1024);
                default: write_reg(CFG_WINDOW_LEN, 16'($urandom_range(1, 40)));
            endcase
            case ($urandom_range(0, 3))
                0: write_reg(CFG_FULL_AFTER, 16'd0);
                1: write_reg(CFG_FULL_AFTER, 16'd255);
                default: write_reg(CFG_FULL_AFTER, 16'($urandom_range(0, 6)));
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            n_frames = $urandom_range(3, 8);
            for (int fr = 0; fr < n_frames && items_sent < 650; fr++)
                random_frame();
        end
        no_idle = 1'b0;
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("particle_depth_sorter_top_tb OK");
        end else begin
            $display("particle_depth_sorter_top_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("particle_depth_sorter_top_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/pds_pkg.sv
hdl/pds_datapath.sv
hdl/pds_ctrl.sv
hdl/particle_depth_sorter_top.sv
dv/particle_depth_sorter_checker.sv
dv/particle_depth_sorter_top_tb.sv
